@@ rtl/isbn_pkg.sv @@
// ----------------------------------------------------------------------------
// isbn_pkg
// Shared constants and checksum functions for the ISBN text scanner.
// ----------------------------------------------------------------------------
package isbn_pkg;

	localparam int CANDIDATE_SLOTS = 24;
	localparam int CHAR_W          = 16;
	localparam int D13_W           = 52;
	localparam int D10_W           = 40;
	localparam int CNT_W           = 4;
	localparam int TDATA_IN_W      = 16;
	localparam int TDATA_OUT_W     = 56;
	localparam int TUSER_OUT_W     = 2;

	localparam logic [CHAR_W-1:0] CH_0      = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_7      = 16'h0037;
	localparam logic [CHAR_W-1:0] CH_8      = 16'h0038;
	localparam logic [CHAR_W-1:0] CH_9      = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_X      = 16'h0058;
	localparam logic [CHAR_W-1:0] CH_X_LOW  = 16'h0078;
	localparam logic [CHAR_W-1:0] CH_HYPHEN = 16'h002D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;

	localparam logic [CNT_W-1:0] NEED13 = 4'd13;
	localparam logic [CNT_W-1:0] NEED10 = 4'd10;
	localparam logic [CNT_W-1:0] PREFIX = 4'd3;
	localparam logic [3:0]       X_CODE = 4'd10;

	// weights 1,3,1,3... ; sum mod 10 via reciprocal 205/2048 (exact below 1029)
	function automatic logic check13(input logic [D13_W-1:0] d);
		logic [7:0]  sum;
		logic [15:0] p;
		logic [7:0]  q;
		logic [7:0]  r;
		sum = '0;
		for (int i = 0; i < 13; i++) begin
			if ((i % 2) == 1) sum = sum + 8'(d[4*(12-i) +: 4]) * 8'd3;
			else              sum = sum + 8'(d[4*(12-i) +: 4]);
		end
		p = 16'(sum) * 16'd205;
		q = 8'(p >> 11);
		r = sum - 8'(q * 8'd10);
		return r == 8'd0;
	endfunction

	// weights 10..1 ; sum mod 11 via reciprocal 2979/32768
	function automatic logic check10(input logic [D10_W-1:0] d);
		logic [9:0]  sum;
		logic [21:0] p;
		logic [9:0]  q;
		logic [9:0]  r;
		sum = '0;
		for (int i = 0; i < 10; i++) begin
			sum = sum + 10'(d[4*(9-i) +: 4]) * 10'(10 - i);
		end
		p = 22'(sum) * 22'd2979;
		q = 10'(p >> 15);
		r = sum - 10'(q * 10'd11);
		return r == 10'd0;
	endfunction

endpackage

@@ rtl/isbn_text_scanner.sv @@
// ----------------------------------------------------------------------------
// isbn_text_scanner
// Scans a UTF-16 text stream for ISBN-13 and ISBN-10 numbers.
// ----------------------------------------------------------------------------
// Usage: text enters on the s_ channel, one code unit per request in
// s_tdata, with s_tlast on the final character of a text. On that final
// character one result leaves on the m_ channel: m_tuser gives found and
// is_thirteen, m_tdata the packed digits (zero when nothing was found).
// Throughput is one character per cycle while s_tready is high; all
// candidate slots of both matchers update in parallel in one pass.
// The accepted last character is registered in the input stage, the slot
// update in the match stage, then the checksum feeds the result register.
// After the last character all slots and the best-match registers clear,
// so the next character starts a new text.
// Reset empties all slots and the pipeline. When the receiver stalls, the
// result waits in the output register while further characters are still
// taken; only a second text end arriving behind a waiting result holds
// s_tready low.
// ----------------------------------------------------------------------------
module isbn_text_scanner #(
	parameter int CANDIDATE_SLOTS = isbn_pkg::CANDIDATE_SLOTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [isbn_pkg::TDATA_IN_W-1:0]     s_tdata,  // [15:0] code_unit
	input  logic                                s_tlast,  // last_char
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [isbn_pkg::TDATA_OUT_W-1:0]    m_tdata,  // [51:0] isbn_digits
	output logic [isbn_pkg::TUSER_OUT_W-1:0]    m_tuser   // [0] found, [1] is_thirteen
);

	localparam int N = CANDIDATE_SLOTS;

	// input stage
	logic                            valid_s1;
	logic [isbn_pkg::CHAR_W-1:0]     ch_s1;
	logic                            last_s1;

	// match stage
	logic                            valid_s2;
	logic                            last_s2;
	logic                            hit13_s2;
	logic                            hit10_s2;
	logic [isbn_pkg::D13_W-1:0]      d13_s2;
	logic [isbn_pkg::D10_W-1:0]      d10_s2;

	// candidate slots
	logic [N-1:0]                    live13_q, sep13_q, live10_q, sep10_q;
	logic [isbn_pkg::CNT_W-1:0]      cnt13_q [N];
	logic [isbn_pkg::CNT_W-1:0]      cnt10_q [N];
	logic [isbn_pkg::D13_W-1:0]      digs13_q [N];
	logic [isbn_pkg::D10_W-1:0]      digs10_q [N];

	logic [N-1:0]                    live13_d, sep13_d, live10_d, sep10_d;
	logic [isbn_pkg::CNT_W-1:0]      cnt13_d [N];
	logic [isbn_pkg::CNT_W-1:0]      cnt10_d [N];
	logic [isbn_pkg::D13_W-1:0]      digs13_d [N];
	logic [isbn_pkg::D10_W-1:0]      digs10_d [N];

	logic                            hit13, hit10;
	logic [isbn_pkg::D13_W-1:0]      d13;
	logic [isbn_pkg::D10_W-1:0]      d10;

	// best matches
	logic                            best13_found_q, best10_found_q;
	logic [isbn_pkg::D13_W-1:0]      best13_q;
	logic [isbn_pkg::D10_W-1:0]      best10_q;

	logic                            out_valid_q;
	logic                            out_found_q, out_thirteen_q;
	logic [isbn_pkg::D13_W-1:0]      out_digs_q;

	logic                            out_free, stall, adv1;
	logic                            is_dig, is_sep, is_x;
	logic [3:0]                      dval;
	logic                            ok13, found_free;
	logic                            c13, c10, nb13, nb10;
	logic [isbn_pkg::D13_W-1:0]      nbd13;
	logic [isbn_pkg::D10_W-1:0]      nbd10;

	assign out_free = !out_valid_q || m_tready;
	assign stall    = valid_s2 && last_s2 && !out_free;
	assign s_tready = !stall;
	assign adv1     = valid_s1 && !stall;

	assign is_dig = (ch_s1 >= isbn_pkg::CH_0) && (ch_s1 <= isbn_pkg::CH_9);
	assign is_sep = (ch_s1 == isbn_pkg::CH_HYPHEN) || (ch_s1 == isbn_pkg::CH_SPACE);
	assign is_x   = (ch_s1 == isbn_pkg::CH_X) || (ch_s1 == isbn_pkg::CH_X_LOW);
	assign dval   = ch_s1[3:0];

	always_comb begin
		hit13 = 1'b0;
		hit10 = 1'b0;
		d13   = '0;
		d10   = '0;
		ok13  = 1'b0;
		found_free = 1'b0;
		live13_d = live13_q;
		sep13_d  = sep13_q;
		live10_d = live10_q;
		sep10_d  = sep10_q;
		cnt13_d  = cnt13_q;
		cnt10_d  = cnt10_q;
		digs13_d = digs13_q;
		digs10_d = digs10_q;

		// advance every live thirteen-digit candidate
		for (int i = 0; i < N; i++) begin
			if (live13_q[i]) begin
				if (cnt13_q[i] < isbn_pkg::PREFIX) begin
					if (cnt13_q[i] == 4'd1) ok13 = (ch_s1 == isbn_pkg::CH_7);
					else ok13 = (ch_s1 == isbn_pkg::CH_8) || (ch_s1 == isbn_pkg::CH_9);
					if (ok13) begin
						digs13_d[i] = {digs13_q[i][isbn_pkg::D13_W-5:0], dval};
						cnt13_d[i]  = cnt13_q[i] + 4'd1;
						sep13_d[i]  = 1'b0;
					end else begin
						live13_d[i] = 1'b0;
					end
				end else if (is_dig) begin
					digs13_d[i] = {digs13_q[i][isbn_pkg::D13_W-5:0], dval};
					cnt13_d[i]  = cnt13_q[i] + 4'd1;
					sep13_d[i]  = 1'b0;
					if (cnt13_q[i] + 4'd1 == isbn_pkg::NEED13) begin
						hit13       = 1'b1;
						d13         = {digs13_q[i][isbn_pkg::D13_W-5:0], dval};
						live13_d[i] = 1'b0;
					end
				end else if (is_sep && !sep13_q[i]) begin
					sep13_d[i] = 1'b1;
				end else begin
					live13_d[i] = 1'b0;
				end
			end
		end

		// advance every live ten-digit candidate
		for (int i = 0; i < N; i++) begin
			if (live10_q[i]) begin
				if (is_dig || (is_x && cnt10_q[i] == 4'd9)) begin
					digs10_d[i] = {digs10_q[i][isbn_pkg::D10_W-5:0],
						(is_dig ? dval : isbn_pkg::X_CODE)};
					cnt10_d[i]  = cnt10_q[i] + 4'd1;
					sep10_d[i]  = 1'b0;
					if (cnt10_q[i] + 4'd1 == isbn_pkg::NEED10) begin
						hit10       = 1'b1;
						d10         = digs10_d[i];
						live10_d[i] = 1'b0;
					end
				end else if (is_sep && !sep10_q[i]) begin
					sep10_d[i] = 1'b1;
				end else begin
					live10_d[i] = 1'b0;
				end
			end
		end

		// a match drops all; else a 9 (ten: any digit) takes the lowest free slot
		if (hit13) begin
			live13_d = '0;
		end else if (ch_s1 == isbn_pkg::CH_9) begin
			found_free = 1'b0;
			for (int i = 0; i < N; i++) begin
				if (!found_free && !live13_d[i]) begin
					found_free  = 1'b1;
					live13_d[i] = 1'b1;
					sep13_d[i]  = 1'b0;
					cnt13_d[i]  = 4'd1;
					digs13_d[i] = isbn_pkg::D13_W'(dval);
				end
			end
		end

		if (hit10) begin
			live10_d = '0;
		end else if (is_dig) begin
			found_free = 1'b0;
			for (int i = 0; i < N; i++) begin
				if (!found_free && !live10_d[i]) begin
					found_free  = 1'b1;
					live10_d[i] = 1'b1;
					sep10_d[i]  = 1'b0;
					cnt10_d[i]  = 4'd1;
					digs10_d[i] = isbn_pkg::D10_W'(dval);
				end
			end
		end

		// end of text clears all candidates
		if (last_s1) begin
			live13_d = '0;
			live10_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			live13_q <= '0;
			live10_q <= '0;
			sep13_q  <= '0;
			sep10_q  <= '0;
		end else if (!stall) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			if (adv1) begin
				live13_q <= live13_d;
				live10_q <= live10_d;
				sep13_q  <= sep13_d;
				sep10_q  <= sep10_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			ch_s1    <= s_tdata;
			last_s1  <= s_tlast && s_tvalid;
			last_s2  <= last_s1;
			hit13_s2 <= hit13 && valid_s1;
			hit10_s2 <= hit10 && valid_s1;
			d13_s2   <= d13;
			d10_s2   <= d10;
			if (adv1) begin
				cnt13_q  <= cnt13_d;
				cnt10_q  <= cnt10_d;
				digs13_q <= digs13_d;
				digs10_q <= digs10_d;
			end
		end
	end

	// checksum and keep the first valid match of each kind
	always_comb begin
		c13   = hit13_s2 && !best13_found_q && isbn_pkg::check13(d13_s2);
		c10   = hit10_s2 && !best10_found_q && isbn_pkg::check10(d10_s2);
		nb13  = best13_found_q || c13;
		nb10  = best10_found_q || c10;
		nbd13 = c13 ? d13_s2 : best13_q;
		nbd10 = c10 ? d10_s2 : best10_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best13_found_q <= 1'b0;
			best10_found_q <= 1'b0;
			best13_q       <= '0;
			best10_q       <= '0;
			out_valid_q    <= 1'b0;
			out_found_q    <= 1'b0;
			out_thirteen_q <= 1'b0;
			out_digs_q     <= '0;
		end else begin
			if (m_tready && !(valid_s2 && last_s2)) out_valid_q <= 1'b0;
			if (valid_s2 && !stall) begin
				if (last_s2) begin
					best13_found_q <= 1'b0;
					best10_found_q <= 1'b0;
					best13_q       <= '0;
					best10_q       <= '0;
					out_valid_q    <= 1'b1;
					out_found_q    <= nb13 || nb10;
					out_thirteen_q <= nb13;
					if (nb13)      out_digs_q <= nbd13;
					else if (nb10) out_digs_q <= isbn_pkg::D13_W'(nbd10);
					else           out_digs_q <= '0;
				end else begin
					best13_found_q <= nb13;
					best10_found_q <= nb10;
					best13_q       <= nbd13;
					best10_q       <= nbd10;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = isbn_pkg::TDATA_OUT_W'(out_digs_q);
	assign m_tuser  = {out_thirteen_q, out_found_q};

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives text streams into the ISBN scanner and checks each text-end result
// against a cycle-free predictor of both matchers.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = isbn_pkg::CANDIDATE_SLOTS;

	typedef struct {
		bit       live;
		bit       sep;
		int       cnt;
		bit [51:0] digs;
	} cand_t;

	typedef struct {
		bit        found;
		bit        thirteen;
		bit [51:0] digits;
	} scan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [isbn_pkg::TDATA_IN_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [isbn_pkg::TDATA_OUT_W-1:0] m_tdata;
	logic [isbn_pkg::TUSER_OUT_W-1:0] m_tuser;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 1'b0;
	int errors = 0;

	cand_t slots13[NSLOT];
	cand_t slots10[NSLOT];
	bit        have13, have10;
	bit [51:0] best13, best10;
	scan_result_t pending_results[$];

	isbn_text_scanner DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	function automatic bit sum13_ok(bit [51:0] d);
		int s;
		s = 0;
		for (int i = 0; i < 13; i++)
			s += d[4*(12-i) +: 4] * ((i & 1) ? 3 : 1);
		return (s % 10) == 0;
	endfunction

	function automatic bit sum10_ok(bit [51:0] d);
		int s;
		s = 0;
		for (int i = 0; i < 10; i++)
			s += d[4*(9-i) +: 4] * (10 - i);
		return (s % 11) == 0;
	endfunction

	function automatic void clear_scan();
		for (int i = 0; i < NSLOT; i++) begin
			slots13[i] = '{default: 0};
			slots10[i] = '{default: 0};
		end
		have13 = 0; have10 = 0; best13 = '0; best10 = '0;
	endfunction

	function automatic bit step_matcher(ref cand_t s[NSLOT], input bit is13,
			input bit [15:0] ch, output bit [51:0] done);
		bit hit, dig, sp, xok;
		int need;
		hit = 0;
		done = '0;
		dig = ch >= isbn_pkg::CH_0 && ch <= isbn_pkg::CH_9;
		sp = ch == isbn_pkg::CH_HYPHEN || ch == isbn_pkg::CH_SPACE;
		need = is13 ? 13 : 10;
		for (int i = 0; i < NSLOT; i++) begin
			if (!s[i].live) continue;
			if (is13 && s[i].cnt < 3) begin
				if ((s[i].cnt == 1) ? (ch == isbn_pkg::CH_7) :
						(ch == isbn_pkg::CH_8 || ch == isbn_pkg::CH_9)) begin
					s[i].digs = {s[i].digs[47:0], 4'(ch - isbn_pkg::CH_0)};
					s[i].cnt++;
				end else
					s[i].live = 0;
				continue;
			end
			xok = !is13 && s[i].cnt == 9 &&
				(ch == isbn_pkg::CH_X || ch == isbn_pkg::CH_X_LOW);
			if (dig || xok) begin
				s[i].digs = {s[i].digs[47:0],
					xok ? isbn_pkg::X_CODE : 4'(ch - isbn_pkg::CH_0)};
				s[i].cnt++;
				s[i].sep = 0;
				if (s[i].cnt >= need) begin
					hit = 1;
					done = s[i].digs;
					s[i].live = 0;
				end
			end else if (sp && !s[i].sep)
				s[i].sep = 1;
			else
				s[i].live = 0;
		end
		return hit;
	endfunction

	function automatic void open_slot(ref cand_t s[NSLOT], input bit [15:0] ch);
		for (int i = 0; i < NSLOT; i++)
			if (!s[i].live) begin
				s[i] = '{live: 1, sep: 0, cnt: 1, digs: 52'(ch - isbn_pkg::CH_0)};
				return;
			end
	endfunction

	function automatic void predict_char(bit [15:0] ch, bit last);
		bit [51:0] d;
		scan_result_t r;
		if (step_matcher(slots13, 1, ch, d)) begin
			for (int i = 0; i < NSLOT; i++) slots13[i] = '{default: 0};
			if (!have13 && sum13_ok(d)) begin have13 = 1; best13 = d; end
		end else if (ch == isbn_pkg::CH_9)
			open_slot(slots13, ch);
		if (step_matcher(slots10, 0, ch, d)) begin
			for (int i = 0; i < NSLOT; i++) slots10[i] = '{default: 0};
			if (!have10 && sum10_ok(d)) begin have10 = 1; best10 = d; end
		end else if (ch >= isbn_pkg::CH_0 && ch <= isbn_pkg::CH_9)
			open_slot(slots10, ch);
		if (!last) return;
		if (have13) r = '{1, 1, best13};
		else if (have10) r = '{1, 0, {12'h0, best10[39:0]}};
		else r = '{0, 0, '0};
		pending_results.push_back(r);
		clear_scan();
	endfunction

	// send one character, idling at random before the request
	task automatic send_char(bit [15:0] ch, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_char(ch, last);
	endtask

	task automatic send_text(string t);
		for (int i = 0; i < t.len(); i++)
			send_char(16'(t[i]), i == t.len() - 1);
	endtask

	always @(posedge clk) begin
		m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with none expected");
				errors++;
			end else begin
				scan_result_t e;
				e = pending_results.pop_front();
				if (m_tuser[0] !== e.found) begin
					$error("found exp %0d got %0d", e.found, m_tuser[0]); errors++;
				end
				if (m_tuser[1] !== e.thirteen) begin
					$error("is_thirteen exp %0d got %0d", e.thirteen, m_tuser[1]); errors++;
				end
				if (m_tdata[51:0] !== e.digits) begin
					$error("isbn_digits exp %h got %h", e.digits, m_tdata[51:0]); errors++;
				end
			end
		end
	end

	// drop the request and wait for every expected result
	task automatic drain();
		int n;
		n = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (10) @(posedge clk);
	endtask

	function automatic string digit_str(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
		return s;
	endfunction

	// build an ISBN-13 or ISBN-10, valid unless corrupt is set, optionally with separators
	function automatic string make_isbn(bit is13, bit corrupt);
		int v[13];
		int s, n;
		string t;
		n = is13 ? 13 : 10;
		for (int i = 0; i < n - 1; i++) v[i] = $urandom_range(9);
		if (is13) begin v[0] = 9; v[1] = 7; v[2] = 8 + $urandom_range(1); end
		s = 0;
		for (int i = 0; i < n - 1; i++) s += is13 ? v[i] * ((i & 1) ? 3 : 1) : v[i] * (10 - i);
		v[n-1] = is13 ? (10 - s % 10) % 10 : (11 - s % 11) % 11;
		if (corrupt) v[n-2] = (v[n-2] + 1) % 10;
		t = "";
		for (int i = 0; i < n; i++) begin
			if (i > (is13 ? 2 : 0) && $urandom_range(3) == 0)
				t = {t, string'($urandom_range(1) ? "-" : " ")};
			if (v[i] == 10) t = {t, string'($urandom_range(1) ? "X" : "x")};
			else t = {t, string'(8'("0" + v[i]))};
		end
		return t;
	endfunction

	task automatic test_directed();
		send_text("ISBN 978-0-306-40615-7");
		send_text("0306406152");
		send_text("080442957X");
		send_text("080442957x tail");
		send_text("no isbn here");
		send_text("978 0306406157 and 0306406152");
		send_text("0306406153 9780306406158");
		send_text("97-80306406157");
		send_text("0--306406152");
		send_text("03064061");
		send_text("x");
		// unusual code units: full-width digit, all ones, zero and a 9 with a high byte set
		send_char(16'hFF10, 0); send_char(16'hFFFF, 0); send_char(16'h0000, 0);
		send_char(16'h8039, 1);
		send_text("99780306406157");
		drain();
	endtask

	task automatic random_texts(int nitems);
		int sent;
		int nnoise;
		string t;
		sent = 0;
		while (sent < nitems) begin
			t = "";
			repeat ($urandom_range(3)) begin
				case ($urandom_range(5))
					0: t = {t, digit_str($urandom_range(1, 6))};
					1: t = {t, " ab-"};
					2, 3: t = {t, make_isbn(1, $urandom_range(3) == 0)};
					default: t = {t, make_isbn(0, $urandom_range(3) == 0)};
				endcase
			end
			if ($urandom_range(4) == 0) begin
				// raw noise with full 16-bit code units
				nnoise = $urandom_range(1, 4);
				repeat (nnoise) send_char(16'($urandom), 0);
				sent += nnoise;
			end
			if (t.len() == 0) t = "9";
			send_text(t);
			sent += t.len();
		end
		drain();
	endtask

	task automatic test_backpressure();
		fork
			begin
				recv_hold = 1;
				repeat (400) @(posedge clk);
				recv_hold = 0;
			end
			begin
				send_text("9780306406157");
				send_text("0306406152");
				send_text("0306406152");
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		join
		drain();
	endtask

	initial begin
		clear_scan();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 38; recv_idle_pct = 52;
		random_texts(300);
		test_backpressure();
		send_idle_pct = 52; recv_idle_pct = 38;
		random_texts(300);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_texts(300);
		drain();
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

@@ isbn_text_scanner.f @@
rtl/isbn_pkg.sv
rtl/isbn_text_scanner.sv
tb/testbench.sv
